[rtl/ssdcw_pkg.sv]
`timescale 1ns / 1ps
// Shared types, bus constants and segment encoding for the seven-segment command writer.
// Used by every module of the block; depends on nothing else.

package ssdcw_pkg;

    localparam int DIGIT_COUNT_DEF = 4;

    // Command codes carried in the action field.
    localparam logic [1:0] ACT_NUMBER  = 2'd0;
    localparam logic [1:0] ACT_TIME    = 2'd1;
    localparam logic [1:0] ACT_CONTROL = 2'd2;
    localparam logic [1:0] ACT_CLEAR   = 2'd3;

    localparam logic [7:0] ADDR_CONTROL = 8'h48;
    localparam logic [7:0] ADDR_DIGIT0  = 8'h68;
    localparam logic [7:0] SEG_DP       = 8'h80;

    // Reciprocal of ten: (x * 52429) >> 19 equals x / 10 for every 16-bit x.
    localparam logic [15:0] RECIP10       = 16'd52429;
    localparam int          RECIP10_SHIFT = 19;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] number;
        logic        zero_fill;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [7:0]  control_byte;
    } cmd_t;

    typedef struct packed {
        logic [7:0] command_address;
        logic [7:0] segment_data;
        logic       last_write;
    } wr_t;

    // Fields that ride along the digit pipeline untouched.
    typedef struct packed {
        logic [1:0] action;
        logic       lead;
        logic [7:0] ctrl;
        logic [3:0] hr_ten;
        logic [3:0] hr_one;
        logic [3:0] mn_ten;
        logic [3:0] mn_one;
    } info_t;

    function automatic logic [7:0] seg_of(input logic [3:0] d);
        logic [7:0] seg;
        unique case (d)
            4'd0:    seg = 8'h3f;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5b;
            4'd3:    seg = 8'h4f;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6d;
            4'd6:    seg = 8'h7d;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7f;
            4'd9:    seg = 8'h6f;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

    // Splits a value below 64 into tens (upper nibble) and units (lower nibble).
    function automatic logic [7:0] split_tens(input logic [5:0] v);
        logic [3:0] t;
        logic [5:0] u;
        if (v >= 6'd60)      t = 4'd6;
        else if (v >= 6'd50) t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else                 t = 4'd0;
        u = v - 6'({t, 3'b000} + {t, 1'b0});
        return {t, u[3:0]};
    endfunction

endpackage

[rtl/ssdcw_digit_pipe.sv]
`timescale 1ns / 1ps
// Digit pipeline: clamps the number, splits hours and minutes, then peels one
// decimal digit per stage. Depends on ssdcw_pkg.

module ssdcw_digit_pipe
    import ssdcw_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  cmd_t                         cmd,
    output logic                         out_valid,
    input  logic                         out_stall,
    output info_t                        out_info,
    output logic [DIGIT_COUNT-1:0][3:0]  out_digits
);

    localparam int NUM_LIMIT = 10 ** DIGIT_COUNT - 1;
    localparam int REM_W     = $clog2(NUM_LIMIT + 1);
    localparam int STAGES    = DIGIT_COUNT + 1;
    localparam int PROD_W    = REM_W + 16;

    logic [STAGES-1:0]                    valid_reg;
    logic [STAGES-1:0]                    valid_next;
    logic [STAGES:0]                      ready;
    info_t                                info_reg   [STAGES];
    logic [REM_W-1:0]                     rem_reg    [STAGES];
    logic [DIGIT_COUNT-1:0][3:0]          digits_reg [STAGES];

    logic [7:0]       hour_split;
    logic [7:0]       min_split;
    logic [REM_W-1:0] clamped;

    // A stage takes new data when it is empty or its content moves on.
    always_comb
    begin
        ready[STAGES] = !out_stall;
        for (int s = STAGES - 1; s >= 0; s--)
        begin
            ready[s] = !valid_reg[s] || ready[s+1];
        end
    end

    always_comb
    begin
        for (int s = 0; s < STAGES; s++)
        begin
            if (ready[s])
                valid_next[s] = (s == 0) ? in_valid : valid_reg[(s == 0) ? 0 : s - 1];
            else
                valid_next[s] = valid_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign hour_split = split_tens({1'b0, cmd.hours});
    assign min_split  = split_tens(cmd.minutes);
    assign clamped    = (cmd.number > 16'(NUM_LIMIT)) ? REM_W'(NUM_LIMIT)
                                                      : cmd.number[REM_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ready[0] && in_valid)
        begin
            info_reg[0].action <= cmd.action;
            info_reg[0].lead   <= cmd.zero_fill;
            info_reg[0].ctrl   <= cmd.control_byte;
            info_reg[0].hr_ten <= hour_split[7:4];
            info_reg[0].hr_one <= hour_split[3:0];
            info_reg[0].mn_ten <= min_split[7:4];
            info_reg[0].mn_one <= min_split[3:0];
            rem_reg[0]         <= clamped;
            digits_reg[0]      <= '0;
        end
    end

    genvar s;
    generate
        for (s = 1; s < STAGES; s++)
        begin : g_digit
            localparam int POS = DIGIT_COUNT - s;

            logic [PROD_W-1:0]           prod;
            logic [REM_W-1:0]            quot;
            logic [REM_W-1:0]            times10;
            logic [REM_W-1:0]            diff;
            logic [DIGIT_COUNT-1:0][3:0] digits_upd;

            assign prod    = PROD_W'(rem_reg[s-1]) * PROD_W'(RECIP10);
            assign quot    = REM_W'(prod >> RECIP10_SHIFT);
            assign times10 = REM_W'({quot, 3'b000} + {quot, 1'b0});
            assign diff    = rem_reg[s-1] - times10;

            always_comb
            begin
                digits_upd      = digits_reg[s-1];
                digits_upd[POS] = diff[3:0];
            end

            always_ff @(posedge clk)
            begin
                if (ready[s] && valid_reg[s-1])
                begin
                    info_reg[s]   <= info_reg[s-1];
                    rem_reg[s]    <= quot;
                    digits_reg[s] <= digits_upd;
                end
            end
        end
    endgenerate

    assign in_stall   = !ready[0];
    assign out_valid  = valid_reg[STAGES-1];
    assign out_info   = info_reg[STAGES-1];
    assign out_digits = digits_reg[STAGES-1];

`ifndef SYNTHESIS
    // The clamped value stays within the displayable range.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] |-> (rem_reg[0] <= REM_W'(NUM_LIMIT)))
        else $error("clamped number out of range");

    // The first and last digits leaving the pipeline are decimal digits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_digits[0] < 4'd10 && out_digits[DIGIT_COUNT-1] < 4'd10))
        else $error("digit split produced a non-decimal digit");

    // A stalled final stage keeps its digits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_digits)))
        else $error("final digit stage changed while stalled");
`endif

endmodule

[rtl/ssdcw_writer.sv]
`timescale 1ns / 1ps
// Write sequencer: formats segment bytes for one command and sends them as
// successive two-byte write transactions. Depends on ssdcw_pkg.

module ssdcw_writer
    import ssdcw_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  info_t                        info,
    input  logic [DIGIT_COUNT-1:0][3:0]  digits,
    output logic                         wr_valid,
    input  logic                         wr_stall,
    output wr_t                          wr
);

    localparam int IDX_W = $clog2(DIGIT_COUNT);

    logic                          valid_reg;
    logic                          valid_next;
    logic [IDX_W-1:0]              idx_reg;
    logic [IDX_W-1:0]              idx_next;
    logic [IDX_W-1:0]              last_idx_reg;
    logic                          ctrl_reg;
    logic [DIGIT_COUNT-1:0][7:0]   data_reg;

    logic [DIGIT_COUNT-1:0][7:0]   fmt_data;
    logic [IDX_W-1:0]              fmt_last;
    logic                          showing;
    logic                          take;
    logic                          is_last;
    logic                          load;

    // Segment bytes for the incoming command.
    always_comb
    begin
        fmt_data = '0;
        fmt_last = IDX_W'(DIGIT_COUNT - 1);
        showing  = info.lead;
        unique case (info.action)
            ACT_NUMBER:
            begin
                for (int i = 0; i < DIGIT_COUNT; i++)
                begin
                    // Leading zeros stay blank unless zero fill is set; the units digit always shows.
                    if (showing || digits[i] != 4'd0 || i == DIGIT_COUNT - 1)
                    begin
                        fmt_data[i] = seg_of(digits[i]);
                        showing     = 1'b1;
                    end
                end
            end
            ACT_TIME:
            begin
                fmt_data[0] = (info.hr_ten != 4'd0) ? seg_of(info.hr_ten) : 8'h00;
                fmt_data[1] = seg_of(info.hr_one) | SEG_DP;
                fmt_data[2] = seg_of(info.mn_ten);
                fmt_data[3] = seg_of(info.mn_one);
            end
            ACT_CONTROL:
            begin
                fmt_data[0] = info.ctrl;
                fmt_last    = '0;
            end
            ACT_CLEAR:
            begin
                fmt_data = '0;
            end
            default:
            begin
                fmt_data = '0;
            end
        endcase
    end

    assign take     = valid_reg && !wr_stall;
    assign is_last  = (idx_reg == last_idx_reg);
    assign in_stall = valid_reg && !(take && is_last);
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
        else if (take)
        begin
            if (is_last)
                valid_next = 1'b0;
            else
                idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg     <= fmt_data;
            last_idx_reg <= fmt_last;
            ctrl_reg     <= (info.action == ACT_CONTROL);
        end
    end

    assign wr_valid           = valid_reg;
    assign wr.command_address = ctrl_reg ? ADDR_CONTROL
                                         : 8'(ADDR_DIGIT0 + {idx_reg, 1'b0});
    assign wr.segment_data    = data_reg[idx_reg];
    assign wr.last_write      = is_last;

`ifndef SYNTHESIS
    // The write index never runs past the command's final write.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (idx_reg <= last_idx_reg))
        else $error("write index beyond last write");

    // A taken transaction that is not the last moves on to the next digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && !is_last) |=> (valid_reg && idx_reg == $past(idx_reg) + 1'b1))
        else $error("write sequence skipped or repeated a digit");

    // A control write is always a single, final transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && ctrl_reg) |-> (idx_reg == '0 && is_last))
        else $error("control write not sent alone");
`endif

endmodule

[rtl/seven_segment_display_command_writer.sv]
`timescale 1ns / 1ps
// Top level of the seven-segment display command writer.
// Depends on ssdcw_pkg, ssdcw_digit_pipe and ssdcw_writer.
//
//   Channel  Valid      Stall      Payload   Direction
//   cmd      cmd_valid  cmd_stall  cmd_t     in:  one display command
//   wr       wr_valid   wr_stall   wr_t      out: one two-byte write transaction
//
// Show number, show time and clear each give four write transactions, one per
// cycle from the writer's output register while wr is not stalled; set control
// gives one transaction. The writer loads the next command as the last write
// of the current one is taken. A command passes six register stages (clamp and
// split, one per decimal digit, then the output register). Reset clears only
// valid bits and the write index. A stall on wr holds the current transaction
// and backs up through the pipeline without loss.

module seven_segment_display_command_writer
    import ssdcw_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cmd_valid,
    output logic  cmd_stall,
    input  cmd_t  cmd,
    output logic  wr_valid,
    input  logic  wr_stall,
    output wr_t   wr
);

    logic                         pipe_valid;
    logic                         pipe_stall;
    info_t                        pipe_info;
    logic [DIGIT_COUNT-1:0][3:0]  pipe_digits;

    ssdcw_digit_pipe #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_digit_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cmd_valid),
        .in_stall   (cmd_stall),
        .cmd        (cmd),
        .out_valid  (pipe_valid),
        .out_stall  (pipe_stall),
        .out_info   (pipe_info),
        .out_digits (pipe_digits)
    );

    ssdcw_writer #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_writer (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pipe_valid),
        .in_stall (pipe_stall),
        .info     (pipe_info),
        .digits   (pipe_digits),
        .wr_valid (wr_valid),
        .wr_stall (wr_stall),
        .wr       (wr)
    );

endmodule
